// File: rtl/sorted_array_min_priority_queue_macros.svh
// ----------------------------------------------------------------------------
// sorted array priority queue assertion macros
// shared concurrent assertion forms, clocked on clk and idle during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_MIN_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_MIN_PRIORITY_QUEUE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define SAPQ_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sapq assertion failed");

// same-cycle implication
`define SAPQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sapq assertion failed");

// next-cycle implication
`define SAPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sapq assertion failed");

`endif

// File: rtl/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// shared sizes, payload structs and the cell command for the priority queue
// ----------------------------------------------------------------------------
package sapq_pkg;

    // store size and field widths
    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 7;

    typedef logic [COUNT_BITS-1:0]        count_t;
    typedef logic signed [VALUE_BITS-1:0] value_t;

    // operation codes
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    // input transfer payload
    typedef struct packed {
        logic   action;
        value_t value;
    } in_t;

    // output transfer payload
    typedef struct packed {
        logic   ok;
        value_t out_value;
        count_t count;
    } out_t;

    // command broadcast to every cell
    typedef struct packed {
        logic   enq;
        logic   deq;
        value_t value;
    } cell_cmd_t;

endpackage

// File: rtl/sapq_cell.sv
// ----------------------------------------------------------------------------
// sapq_cell
// one slot of the sorted chain: compares the broadcast value and takes
// the new value, its lower neighbor's value or its upper neighbor's value
// ----------------------------------------------------------------------------
module sapq_cell (
    input  logic                clk,
    input  sapq_pkg::cell_cmd_t cmd,
    input  logic                occupied,
    input  logic                prev_lt,
    input  sapq_pkg::value_t    prev_data,
    input  sapq_pkg::value_t    next_data,
    output logic                lt,
    output sapq_pkg::value_t    data
);

    sapq_pkg::value_t data_reg;
    sapq_pkg::value_t data_next;

    // cell is occupied and its held value is strictly smaller than the incoming one
    assign lt = occupied && (data_reg < cmd.value);

    // insert: keep if smaller, else take new value or shift up from below
    // remove: shift down from above
    always_comb
    begin
        data_next = data_reg;
        if (cmd.enq && !lt)
        begin
            data_next = prev_lt ? cmd.value : prev_data;
        end
        else if (cmd.deq)
        begin
            data_next = next_data;
        end
    end

    // payload register, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/sorted_array_min_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_array_min_priority_queue
// minimum priority queue of signed values held in a chain of sorting cells
// ----------------------------------------------------------------------------
// One transfer is taken per clock cycle and its result appears in the output
// register on the next cycle, so the unstalled rate is one operation per
// cycle. The cells hold the values smallest first: an enqueue compares its
// value against every cell at once and each cell keeps its value, takes the
// new one or takes its lower neighbor's, and a dequeue returns cell zero
// while every cell takes its upper neighbor's value. The input is ready
// whenever the output register is empty or being drained. Enqueues fail
// with ok low once the count reaches the smaller of cap_reg and the
// store depth; dequeues on an empty queue fail with a zero value. The store
// needs no clearing after reset, so the first transfer may come at once.
// ----------------------------------------------------------------------------
`include "sorted_array_min_priority_queue_macros.svh"

module sorted_array_min_priority_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  sapq_pkg::count_t       cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  sapq_pkg::in_t          in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sapq_pkg::out_t         out_data
);

    sapq_pkg::count_t    count_reg;
    sapq_pkg::count_t    count_next;
    sapq_pkg::count_t    cap_reg;
    sapq_pkg::count_t    cap_eff;
    logic                out_valid_reg;
    sapq_pkg::out_t      out_data_reg;
    sapq_pkg::out_t      out_data_next;
    logic                accept;
    logic                enq_ok;
    logic                deq_ok;
    sapq_pkg::cell_cmd_t cmd;

    logic                   occupied [sapq_pkg::DEPTH];
    logic                   cell_lt  [sapq_pkg::DEPTH];
    sapq_pkg::value_t       cell_data[sapq_pkg::DEPTH];

    // handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // capacity clipped to the store depth
    assign cap_eff = (cap_reg > sapq_pkg::count_t'(sapq_pkg::DEPTH))
                   ? sapq_pkg::count_t'(sapq_pkg::DEPTH) : cap_reg;

    // operation decode
    assign enq_ok = accept && (in_data.action == sapq_pkg::ACT_ENQUEUE)
                  && (count_reg < cap_eff);
    assign deq_ok = accept && (in_data.action == sapq_pkg::ACT_DEQUEUE)
                  && (count_reg != '0);

    assign cmd.enq   = enq_ok;
    assign cmd.deq   = deq_ok;
    assign cmd.value = in_data.value;

    // chain of cells, cell zero holds the minimum
    for (genvar i = 0; i < sapq_pkg::DEPTH; i++)
    begin : g_cell
        logic             prev_lt;
        sapq_pkg::value_t prev_data;
        sapq_pkg::value_t next_data;

        assign occupied[i] = (sapq_pkg::count_t'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign prev_lt   = 1'b1;
            assign prev_data = '0;
        end
        else
        begin : g_inner
            assign prev_lt   = cell_lt[i-1];
            assign prev_data = cell_data[i-1];
        end

        if (i == sapq_pkg::DEPTH - 1)
        begin : g_last
            assign next_data = '0;
        end
        else
        begin : g_below
            assign next_data = cell_data[i+1];
        end

        sapq_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .occupied  (occupied[i]),
            .prev_lt   (prev_lt),
            .prev_data (prev_data),
            .next_data (next_data),
            .lt        (cell_lt[i]),
            .data      (cell_data[i])
        );
    end

    // count and result
    always_comb
    begin
        count_next = count_reg;
        if (enq_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq_ok)
        begin
            count_next = count_reg - 1'b1;
        end
        out_data_next.ok        = enq_ok || deq_ok;
        out_data_next.out_value = deq_ok ? cell_data[0] : '0;
        out_data_next.count     = count_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= sapq_pkg::count_t'(sapq_pkg::DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // assertions
    `SAPQ_ASSERT_ALWAYS(a_count_in_range, count_reg <= sapq_pkg::count_t'(sapq_pkg::DEPTH))
    `SAPQ_ASSERT_IMPL(a_min_first, count_reg >= 7'd2, cell_data[0] <= cell_data[1])
    `SAPQ_ASSERT_NEXT(a_enq_count, enq_ok, count_reg == $past(count_reg) + 7'd1)
    `SAPQ_ASSERT_IMPL(a_fail_zero, out_valid_reg && !out_data_reg.ok, out_data_reg.out_value == '0)

endmodule
